[sv/tni_pkg.sv]
// ----------------------------------------------------------------------------
// tni_pkg: shared types and constants of the table next iterator
// Holds the store depths, the item and status codes and the queue entry type.
// ----------------------------------------------------------------------------
package tni_pkg;

  localparam int ArrayDepth = 256;
  localparam int FieldDepth = 256;
  localparam int ArrayAw    = $clog2(ArrayDepth);
  localparam int FieldAw    = $clog2(FieldDepth);
  localparam int LimW       = 9;

  localparam logic [1:0] ModeWrArray = 2'd0;
  localparam logic [1:0] ModeWrField = 2'd1;
  localparam logic [1:0] ModeNext    = 2'd2;
  localparam logic [1:0] ModeIpairs  = 2'd3;

  localparam logic [1:0] KeyNil   = 2'd0;
  localparam logic [1:0] KeyInt   = 2'd1;
  localparam logic [1:0] KeyStr   = 2'd2;

  // Key kinds of a result word.
  localparam logic [1:0] ResKeyInt   = 2'd1;
  localparam logic [1:0] ResKeyShort = 2'd2;
  localparam logic [1:0] ResKeyLong  = 2'd3;

  localparam logic [2:0] StFound     = 3'd0;
  localparam logic [2:0] StExhausted = 3'd1;
  localparam logic [2:0] StRejected  = 3'd2;
  localparam logic [2:0] StGuard     = 3'd3;
  localparam logic [2:0] StWriteDone = 3'd4;

  localparam logic [1:0] RegArrayUse = 2'd0;
  localparam logic [1:0] RegFieldUse = 2'd1;
  localparam logic [1:0] RegFlavour  = 2'd2;

  // Work kinds the front end hands to the back end.
  typedef enum logic [2:0] {
    OpWrArray, OpWrField, OpFail, OpExhaust, OpArrayWalk, OpStrSearch, OpIpairs
  } op_e;

  typedef struct packed {
    op_e          op;
    logic [8:0]   start;
    logic         occ;
    logic         lng;
    logic [3:0]   vtag;
    logic [63:0]  vpay;
    logic [47:0]  kref;
  } cmd_t;

  typedef enum logic [2:0] {
    BkIdle, BkArrRd, BkArrChk, BkFldRd, BkFldChk, BkOut
  } bk_state_e;

endpackage

[sv/tni_ram.sv]
// ----------------------------------------------------------------------------
// tni_ram: generic single-port RAM
// One write or one read a cycle; read data registered.
// ----------------------------------------------------------------------------
module tni_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[sv/tni_front.sv]
// ----------------------------------------------------------------------------
// tni_front: item classifier
// Checks the table and key of each word and turns it into a back-end command.
// ----------------------------------------------------------------------------
module tni_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         slot_index_i,
  input  logic               slot_occupied_i,
  input  logic               slot_key_long_i,
  input  logic [3:0]         value_tag_i,
  input  logic [63:0]        value_payload_i,
  input  logic               table_usable_i,
  input  logic [1:0]         key_tag_i,
  input  logic signed [63:0] key_integer_i,
  input  logic [47:0]        key_ref_i,
  input  logic [8:0]         arr_lim_i,
  output logic               q_push_o,
  input  logic               q_full_i,
  output tni_pkg::cmd_t      q_cmd_o
);
  logic neg, zero, past;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign neg  = key_integer_i[63];
  assign zero = key_integer_i == 64'sd0;
  assign past = key_integer_i[62:9] != '0 || key_integer_i[8:0] >= arr_lim_i;

  always_comb begin
    q_cmd_o       = '0;
    q_cmd_o.op    = tni_pkg::OpFail;
    q_cmd_o.occ   = slot_occupied_i;
    q_cmd_o.lng   = slot_key_long_i;
    q_cmd_o.vtag  = value_tag_i;
    q_cmd_o.vpay  = value_payload_i;
    q_cmd_o.kref  = key_ref_i;
    q_cmd_o.start = {1'b0, slot_index_i};
    case (mode_i)
      tni_pkg::ModeWrArray: q_cmd_o.op = tni_pkg::OpWrArray;
      tni_pkg::ModeWrField: q_cmd_o.op = tni_pkg::OpWrField;
      tni_pkg::ModeNext: begin
        if (!table_usable_i) begin
          q_cmd_o.op = tni_pkg::OpFail;
        end else if (key_tag_i == tni_pkg::KeyNil) begin
          q_cmd_o.op = tni_pkg::OpArrayWalk; q_cmd_o.start = '0;
        end else if (key_tag_i == tni_pkg::KeyInt) begin
          q_cmd_o.op = tni_pkg::OpArrayWalk;
          if (neg || zero) q_cmd_o.start = '0;
          else if (past)   q_cmd_o.start = arr_lim_i;
          else             q_cmd_o.start = key_integer_i[8:0];
        end else if (key_tag_i == tni_pkg::KeyStr) begin
          q_cmd_o.op = tni_pkg::OpStrSearch;
        end else begin
          q_cmd_o.op = tni_pkg::OpFail;
        end
      end
      default: begin
        if (!table_usable_i || key_tag_i != tni_pkg::KeyInt) begin
          q_cmd_o.op = tni_pkg::OpFail;
        end else if (neg || past) begin
          q_cmd_o.op = tni_pkg::OpExhaust;
        end else begin
          q_cmd_o.op = tni_pkg::OpIpairs; q_cmd_o.start = key_integer_i[8:0];
        end
      end
    endcase
  end
endmodule

[sv/tni_queue.sv]
// ----------------------------------------------------------------------------
// tni_queue: two-entry command queue
// Decouples the classifier from the table walker.
// ----------------------------------------------------------------------------
module tni_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tni_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output tni_pkg::cmd_t cmd_o
);
  tni_pkg::cmd_t ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign cmd_o   = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  ovf_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("queue overflow");
  udf_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("queue underflow");
  cnt_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
endmodule

[sv/tni_back.sv]
// ----------------------------------------------------------------------------
// tni_back: table walker
// Owns the stores, runs writes and scans, and holds the result word.
// ----------------------------------------------------------------------------
module tni_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  tni_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  input  logic [8:0]    arr_lim_i,
  input  logic [8:0]    fld_lim_i,
  input  logic          flavour_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    status_o,
  output logic [1:0]    result_key_tag_o,
  output logic [8:0]    result_key_integer_o,
  output logic [47:0]   result_key_ref_o,
  output logic [3:0]    result_value_tag_o,
  output logic [63:0]   result_value_payload_o
);
  tni_pkg::bk_state_e st_q, st_d;
  tni_pkg::cmd_t cmd_q;
  logic [8:0]  idx_q, idx_d;
  logic        match_q, match_d;   // string search: key seen, now seeking next
  logic        ld_cmd;
  logic [2:0]  ost_q, ost_d;
  logic [1:0]  okt_q, okt_d;
  logic [8:0]  oki_q, oki_d;
  logic [47:0] okr_q, okr_d;
  logic [3:0]  ovt_q, ovt_d;
  logic [63:0] ovp_q, ovp_d;

  logic        a_we, f_we;
  logic [7:0]  a_addr, f_addr;
  logic [3:0]  a_tag, f_vtag;
  logic [63:0] a_pay, f_vpay;
  logic        f_mark, f_lng;
  logic [47:0] f_ref;

  tni_pkg::cmd_t cc;
  assign cc = (st_q == tni_pkg::BkIdle) ? q_cmd_i : cmd_q;

  assign a_we   = st_q == tni_pkg::BkIdle && !q_empty_i && !out_valid_o &&
                  q_cmd_i.op == tni_pkg::OpWrArray;
  assign f_we   = st_q == tni_pkg::BkIdle && !q_empty_i && !out_valid_o &&
                  q_cmd_i.op == tni_pkg::OpWrField;
  assign a_addr = (a_we) ? q_cmd_i.start[7:0] : idx_q[7:0];
  assign f_addr = (f_we) ? q_cmd_i.start[7:0] : idx_q[7:0];

  tni_ram #(.Width(68), .Depth(tni_pkg::ArrayDepth)) u_arr (
    .clk_i, .we_i(a_we), .addr_i(a_addr),
    .wdata_i({q_cmd_i.vtag, q_cmd_i.vpay}), .rdata_o({a_tag, a_pay}));
  tni_ram #(.Width(118), .Depth(tni_pkg::FieldDepth)) u_fld (
    .clk_i, .we_i(f_we), .addr_i(f_addr),
    .wdata_i({q_cmd_i.occ, q_cmd_i.lng, q_cmd_i.kref, q_cmd_i.vtag, q_cmd_i.vpay}),
    .rdata_o({f_mark, f_lng, f_ref, f_vtag, f_vpay}));

  assign ld_cmd  = st_q == tni_pkg::BkIdle && !q_empty_i && !out_valid_o;
  assign q_pop_o = ld_cmd;

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      tni_pkg::BkIdle: if (ld_cmd) begin
        case (q_cmd_i.op)
          tni_pkg::OpArrayWalk: st_d = (q_cmd_i.start < arr_lim_i) ?
                                       tni_pkg::BkArrRd : tni_pkg::BkFldRd;
          tni_pkg::OpIpairs:    st_d = tni_pkg::BkArrRd;
          tni_pkg::OpStrSearch: st_d = tni_pkg::BkFldRd;
          default:              st_d = tni_pkg::BkOut;
        endcase
      end
      tni_pkg::BkArrRd: st_d = tni_pkg::BkArrChk;
      tni_pkg::BkArrChk: begin
        if (a_tag != '0 || cmd_q.op == tni_pkg::OpIpairs) st_d = tni_pkg::BkOut;
        else if (idx_q + 9'd1 < arr_lim_i) st_d = tni_pkg::BkArrRd;
        else st_d = tni_pkg::BkFldRd;
      end
      tni_pkg::BkFldRd: st_d = (idx_q < fld_lim_i) ? tni_pkg::BkFldChk : tni_pkg::BkOut;
      tni_pkg::BkFldChk: begin
        if (f_mark && (cmd_q.op != tni_pkg::OpStrSearch || match_q))
          st_d = tni_pkg::BkOut;
        else st_d = tni_pkg::BkFldRd;
      end
      tni_pkg::BkOut: st_d = tni_pkg::BkIdle;
      default: st_d = tni_pkg::BkIdle;
    endcase
  end

  // Datapath and result.
  always_comb begin
    idx_d = idx_q; match_d = match_q;
    ost_d = ost_q; okt_d = okt_q; oki_d = oki_q; okr_d = okr_q;
    ovt_d = ovt_q; ovp_d = ovp_q;
    case (st_q)
      tni_pkg::BkIdle: if (ld_cmd) begin
        match_d = 1'b0;
        {okt_d, oki_d, okr_d, ovt_d, ovp_d} = '0;
        case (q_cmd_i.op)
          tni_pkg::OpWrArray, tni_pkg::OpWrField: ost_d = tni_pkg::StWriteDone;
          tni_pkg::OpFail: ost_d = flavour_i ? tni_pkg::StGuard : tni_pkg::StRejected;
          default: ost_d = tni_pkg::StExhausted;
        endcase
        idx_d = (q_cmd_i.op == tni_pkg::OpArrayWalk && q_cmd_i.start < arr_lim_i) ||
                q_cmd_i.op == tni_pkg::OpIpairs ? q_cmd_i.start : '0;
      end
      tni_pkg::BkArrChk: begin
        if (a_tag != '0) begin
          ost_d = tni_pkg::StFound; okt_d = tni_pkg::ResKeyInt;
          oki_d = idx_q + 9'd1; ovt_d = a_tag; ovp_d = a_pay;
        end else if (idx_q + 9'd1 < arr_lim_i) idx_d = idx_q + 9'd1;
        else idx_d = '0;
      end
      tni_pkg::BkFldChk: begin
        if (f_mark && (cmd_q.op != tni_pkg::OpStrSearch || match_q)) begin
          ost_d = tni_pkg::StFound;
          okt_d = f_lng ? tni_pkg::ResKeyLong : tni_pkg::ResKeyShort;
          okr_d = f_ref; ovt_d = f_vtag; ovp_d = f_vpay;
        end else begin
          if (f_mark && f_ref == cmd_q.kref) match_d = 1'b1;
          idx_d = idx_q + 9'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld_cmd) cmd_q <= cc;
    okt_q <= okt_d; oki_q <= oki_d; okr_q <= okr_d;
    ovt_q <= ovt_d; ovp_q <= ovp_d; idx_q <= idx_d; ost_q <= ost_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= tni_pkg::BkIdle; out_valid_o <= 1'b0; match_q <= 1'b0;
    end else begin
      st_q <= st_d; match_q <= match_d;
      if (st_q == tni_pkg::BkOut) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  assign status_o               = ost_q;
  assign result_key_tag_o       = okt_q;
  assign result_key_integer_o   = oki_q;
  assign result_key_ref_o       = okr_q;
  assign result_value_tag_o     = ovt_q;
  assign result_value_payload_o = ovp_q;

  busy_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  hold_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> st_q == tni_pkg::BkIdle) else $error("walk ran past result");
  wr_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(a_we && f_we)) else $error("two stores written at once");
endmodule

[sv/table_next_iterator.sv]
// ----------------------------------------------------------------------------
// table_next_iterator: Lua-style next/ipairs iteration over one stored table
// Top level with the register port, the classifier, queue and table walker.
// ----------------------------------------------------------------------------
// Each input word is classified at once by the front end and queued in a
// two-entry queue; the back end then runs it against the array and field
// stores, each a single-port RAM with registered read. A write or a failed
// query goes from idle straight to the BkOut state, which sets its result word
// valid. A next query walks the array part from its start slot and then the
// field part, each slot taking a read state and a check state. An ipairs
// query reads one slot. The front end keeps taking words while the queue has
// room, and the result word waits in its own register until taken. Registers
// are written over the APB-style port at byte addresses 0, 4 and 8; the user
// must write them only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module table_next_iterator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         slot_index_i,
  input  logic               slot_occupied_i,
  input  logic               slot_key_long_i,
  input  logic [3:0]         value_tag_i,
  input  logic [63:0]        value_payload_i,
  input  logic               table_usable_i,
  input  logic [1:0]         key_tag_i,
  input  logic signed [63:0] key_integer_i,
  input  logic [47:0]        key_ref_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [1:0]         result_key_tag_o,
  output logic [8:0]         result_key_integer_o,
  output logic [47:0]        result_key_ref_o,
  output logic [3:0]         result_value_tag_o,
  output logic [63:0]        result_value_payload_o
);
  logic [8:0] arr_use_q, fld_use_q, arr_lim, fld_lim;
  logic       flav_q, wr;
  logic       q_push, q_full, q_pop, q_empty;
  tni_pkg::cmd_t cmd_in, cmd_out;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arr_use_q <= '0; fld_use_q <= '0; flav_q <= 1'b0;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        tni_pkg::RegArrayUse: arr_use_q <= pwdata[8:0];
        tni_pkg::RegFieldUse: fld_use_q <= pwdata[8:0];
        tni_pkg::RegFlavour:  flav_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tni_pkg::RegArrayUse: prdata = {23'd0, arr_use_q};
      tni_pkg::RegFieldUse: prdata = {23'd0, fld_use_q};
      tni_pkg::RegFlavour:  prdata = {31'd0, flav_q};
      default:              prdata = '0;
    endcase
  end

  // Counts above the store depth act as the depth.
  assign arr_lim = (arr_use_q > 9'(tni_pkg::ArrayDepth)) ? 9'(tni_pkg::ArrayDepth) : arr_use_q;
  assign fld_lim = (fld_use_q > 9'(tni_pkg::FieldDepth)) ? 9'(tni_pkg::FieldDepth) : fld_use_q;

  tni_front u_front (
    .in_valid_i, .in_ready_o, .mode_i, .slot_index_i, .slot_occupied_i,
    .slot_key_long_i, .value_tag_i, .value_payload_i, .table_usable_i,
    .key_tag_i, .key_integer_i, .key_ref_i, .arr_lim_i(arr_lim),
    .q_push_o(q_push), .q_full_i(q_full), .q_cmd_o(cmd_in));

  tni_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .cmd_i(cmd_in), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .cmd_o(cmd_out));

  tni_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_cmd_i(cmd_out), .q_pop_o(q_pop),
    .arr_lim_i(arr_lim), .fld_lim_i(fld_lim), .flavour_i(flav_q),
    .out_valid_o, .out_ready_i, .status_o, .result_key_tag_o,
    .result_key_integer_o, .result_key_ref_o, .result_value_tag_o,
    .result_value_payload_o);
endmodule
